>>> rtl/bf5_pkg.sv
// bf5_pkg: shared types, sizes and helpers of the 5x5 mean box filter
// used by bf5_front, bf5_queue, bf5_back and box_filter_5x5_mean
// no dependencies
package bf5_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int DIM_W       = 11;
   localparam int ROW_W       = 11;
   localparam int TOTAL_W     = 21;
   localparam int THR_W       = 12;
   localparam int PIX_W       = 8;
   localparam int WIN         = 5;
   localparam int STORE_ROWS  = 4;
   localparam int SLOT_W      = 2;
   localparam int COLSUM_W    = 11;
   localparam int SUM_W       = 13;

   // floor(x / 25) == (x * 5243) >> 17 for every x below 6400
   localparam int RECIP_W     = 13;
   localparam int MEAN_RECIP  = 5243;
   localparam int RECIP_SHIFT = 17;
   localparam int PROD_W      = SUM_W + RECIP_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W  = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = CSR_ADDR_W'(1);

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [DIM_W-1:0]   RESET_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0]   RESET_HEIGHT = DIM_W'(480);
   localparam logic [TOTAL_W-1:0] RESET_TOTAL  = TOTAL_W'(640 * 480);

   typedef struct packed {
      logic             operation;
      logic [PIX_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] mean;
      logic             last_of_frame;
   } rsp_type;

   // one window column as it travels from front to back
   typedef struct packed {
      logic [COLSUM_W-1:0] colsum;
      logic                emit;
      logic                last;
      logic [WIN-1:0]      col_mask;
   } q_entry_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

>>> rtl/bf5_front.sv
// bf5_front: frame registers, raster counters, four-row line store and column build
// depends on bf5_pkg; feeds bf5_queue
module bf5_front import bf5_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   input  logic                  csr_valid,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [DIM_W-1:0]      csr_wdata,
   input  logic [QCNT_W-1:0]     q_count,
   output logic                  push,
   output q_entry_type           push_entry,
   output logic                  restart
);

   logic [DIM_W-1:0]   wc_ff, wc_in, hc_ff, hc_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [COL_W-1:0]   col_ff, col_in, ocol_ff, ocol_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [TOTAL_W-1:0] head_ff, head_in;

   logic                  f1_valid_ff;
   logic [PIX_W-1:0]      f1_pix_ff;
   logic [STORE_ROWS-1:0] f1_rmask_ff;
   logic [SLOT_W-1:0]     f1_rot_ff;
   logic                  f1_emit_ff, f1_last_ff;
   logic [WIN-1:0]        f1_omask_ff;

   logic                  accept, take, in_frame, emit, last, wr_en;
   logic [THR_W-1:0]      emit_thr;
   logic [TOTAL_W-1:0]    last_thr;
   logic [STORE_ROWS-1:0] rmask;
   logic [WIN-1:0]        omask;
   logic [THR_W-1:0]      rsum, cj;
   logic [PIX_W-1:0]      rd_data [STORE_ROWS];
   logic [COLSUM_W-1:0]   colsum;
   logic [SLOT_W-1:0]     slot;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (q_count + QCNT_W'(f1_valid_ff)) >= QCNT_W'(QUEUE_DEPTH);
   assign restart   = csr_valid && (csr_addr == CSR_FRAME_WIDTH ||
                                    csr_addr == CSR_FRAME_HEIGHT);

   // frame size registers, total pixel count follows the clamped values
   always_comb begin
      wc_in = wc_ff;
      hc_in = hc_ff;
      if (csr_valid && csr_addr == CSR_FRAME_WIDTH) begin
         wc_in = clamp_dim(csr_wdata, DIM_W'(MAX_WIDTH));
      end else if (csr_valid && csr_addr == CSR_FRAME_HEIGHT) begin
         hc_in = clamp_dim(csr_wdata, DIM_W'(MAX_HEIGHT));
      end
      total_in = TOTAL_W'(wc_in) * TOTAL_W'(hc_in);
   end

   // classify the item against the raster position
   assign in_frame = head_ff < total_ff;
   assign take     = accept && !(in_frame && req_data.operation == OP_FLUSH);
   assign emit_thr = (THR_W'(wc_ff) << 1) + THR_W'(2);
   assign emit     = head_ff >= TOTAL_W'(emit_thr);
   assign last_thr = total_ff + TOTAL_W'({wc_ff, 1'b1});
   assign last     = head_ff >= last_thr;
   assign wr_en    = take && in_frame;

   always_comb begin
      rsum = '0;
      cj   = '0;
      for (int dy = 0; dy < STORE_ROWS; dy++) begin
         rsum      = THR_W'(row_ff) + THR_W'(dy);
         rmask[dy] = (rsum >= THR_W'(4)) && ((rsum - THR_W'(4)) < THR_W'(hc_ff));
      end
      for (int j = 0; j < WIN; j++) begin
         cj       = THR_W'(ocol_ff) + THR_W'(j);
         omask[j] = (cj >= THR_W'(2)) && ((cj - THR_W'(2)) < THR_W'(wc_ff));
      end
   end

   // raster counters
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      head_in = head_ff;
      ocol_in = ocol_ff;
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         head_in = '0;
         ocol_in = '0;
      end else if (take) begin
         if (emit && last) begin
            col_in  = '0;
            row_in  = '0;
            head_in = '0;
            ocol_in = '0;
         end else begin
            head_in = head_ff + TOTAL_W'(1);
            if (DIM_W'(col_ff) + DIM_W'(1) >= wc_ff) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
            if (emit) begin
               if (DIM_W'(ocol_ff) + DIM_W'(1) >= wc_ff) begin
                  ocol_in = '0;
               end else begin
                  ocol_in = ocol_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff       <= RESET_WIDTH;
         hc_ff       <= RESET_HEIGHT;
         total_ff    <= RESET_TOTAL;
         col_ff      <= '0;
         row_ff      <= '0;
         head_ff     <= '0;
         ocol_ff     <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         wc_ff       <= wc_in;
         hc_ff       <= hc_in;
         total_ff    <= total_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         head_ff     <= head_in;
         ocol_ff     <= ocol_in;
         f1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         f1_pix_ff   <= in_frame ? req_data.pixel : '0;
         f1_rmask_ff <= rmask;
         f1_rot_ff   <= row_ff[SLOT_W-1:0];
         f1_emit_ff  <= emit;
         f1_last_ff  <= last;
         f1_omask_ff <= omask;
      end
   end

   // one byte-wide memory per stored row, read before write at the same address
   for (genvar s = 0; s < STORE_ROWS; s++) begin : g_row
      logic [PIX_W-1:0] row_mem [MAX_WIDTH];
      always_ff @(posedge clock) begin
         rd_data[s] <= row_mem[col_ff];
         if (wr_en && row_ff[SLOT_W-1:0] == SLOT_W'(s)) begin
            row_mem[col_ff] <= req_data.pixel;
         end
      end
   end

   // rows row-4 .. row-1 sit in slots (row+dy) mod 4
   always_comb begin
      colsum = COLSUM_W'(f1_pix_ff);
      slot   = '0;
      for (int dy = 0; dy < STORE_ROWS; dy++) begin
         slot = f1_rot_ff + SLOT_W'(dy);
         if (f1_rmask_ff[dy]) begin
            colsum = colsum + COLSUM_W'(rd_data[slot]);
         end
      end
   end

   assign push                = f1_valid_ff;
   assign push_entry.colsum   = colsum;
   assign push_entry.emit     = f1_emit_ff;
   assign push_entry.last     = f1_last_ff;
   assign push_entry.col_mask = f1_omask_ff;

endmodule

>>> rtl/bf5_queue.sv
// bf5_queue: small register queue of window columns between front and back
// depends on bf5_pkg
module bf5_queue import bf5_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  q_entry_type       push_entry,
   input  logic              pop,
   output q_entry_type       head,
   output logic              empty,
   output logic [QCNT_W-1:0] count
);

   q_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = count_ff == '0;
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < QCNT_W'(QUEUE_DEPTH))
      else $error("queue push while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue pop while empty");

   a_count_up : assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("queue count did not follow a push");

endmodule

>>> rtl/bf5_back.sv
// bf5_back: 5-column window of column sums, masked window sum and divide by 25
// depends on bf5_pkg; drains bf5_queue
module bf5_back import bf5_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        clear,
   input  logic        q_empty,
   input  q_entry_type q_head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   logic [COLSUM_W-1:0] win_ff [WIN];
   logic [COLSUM_W-1:0] shf [WIN];
   logic                s1_valid_ff, s1_last_ff, rsp_valid_ff;
   logic [SUM_W-1:0]    s1_sum_ff, sum_in;
   logic [PROD_W-1:0]   prod;
   rsp_type             rsp_data_ff;
   logic                adv;

   // the whole back end moves when the output register is free or being taken
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && !q_empty;

   always_comb begin
      for (int j = 0; j < WIN - 1; j++) begin
         shf[j] = win_ff[j + 1];
      end
      shf[WIN - 1] = q_head.colsum;
      sum_in = '0;
      for (int j = 0; j < WIN; j++) begin
         if (q_head.col_mask[j]) begin
            sum_in = sum_in + SUM_W'(shf[j]);
         end
      end
   end

   assign prod = PROD_W'(s1_sum_ff) * PROD_W'(MEAN_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < WIN; j++) begin
            win_ff[j] <= '0;
         end
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clear) begin
            for (int j = 0; j < WIN; j++) begin
               win_ff[j] <= '0;
            end
         end else if (pop) begin
            for (int j = 0; j < WIN; j++) begin
               win_ff[j] <= q_head.last ? '0 : shf[j];
            end
         end
         if (adv) begin
            s1_valid_ff  <= pop && q_head.emit;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_sum_ff  <= sum_in;
         s1_last_ff <= q_head.last;
      end
      if (adv && s1_valid_ff) begin
         rsp_data_ff.mean          <= prod[RECIP_SHIFT +: PIX_W];
         rsp_data_ff.last_of_frame <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_last_clears_window : assert property (@(posedge clock) disable iff (reset)
      pop && q_head.last |=> win_ff[0] == '0 && win_ff[1] == '0 && win_ff[2] == '0 &&
                             win_ff[3] == '0 && win_ff[4] == '0)
      else $error("window not cleared after the frame's last column");

   a_sum_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !adv |=> $stable(s1_sum_ff) && s1_valid_ff)
      else $error("window sum stage moved while the output was stalled");

endmodule

>>> rtl/box_filter_5x5_mean.sv
// box_filter_5x5_mean: top level of the zero-padded 5x5 mean filter
// depends on bf5_pkg, bf5_front, bf5_queue, bf5_back
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  req     | in        | req_valid/req_stall | req_type: operation, pixel
//  rsp     | out       | rsp_valid/rsp_stall | rsp_type: mean, last_of_frame
//  csr     | in        | csr_valid/csr_ready | csr_addr index, csr_wdata value
//
//  one item per clock while rsp_stall is low; the front line store has one read
//  and one write port per row memory, which sets the one-transfer-per-cycle rate
//  the item that completes a window passes the line store read register, the queue,
//  the window sum register and the divide by reciprocal into the output register
//  synchronous active-high reset: frame 640 x 480, counters and window zero,
//  line store contents undefined and never read before being written
//  rsp_stall freezes the back end only; the front keeps taking items until
//  the four-entry queue and the in-flight column fill it
module box_filter_5x5_mean import bf5_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [DIM_W-1:0]      csr_wdata
);

   // front to queue
   logic              push;
   q_entry_type       push_entry;
   logic [QCNT_W-1:0] q_count;

   // queue to back
   logic              pop;
   logic              q_empty;
   q_entry_type       q_head;

   // a size write restarts the frame on both sides
   logic              restart;

   // register writes are taken at any time; the user writes only while idle
   assign csr_ready = 1'b1;

   // front: classify each transfer, keep raster position, read and fill line store
   bf5_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_count    (q_count),
      .push       (push),
      .push_entry (push_entry),
      .restart    (restart)
   );

   // decoupling queue of finished window columns
   bf5_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (q_head),
      .empty      (q_empty),
      .count      (q_count)
   );

   // back: slide the window, add masked columns, divide by 25
   bf5_back u_back (
      .clock     (clock),
      .reset     (reset),
      .clear     (restart),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
